/* design/audio_matrix_mixer_defines.svh */
// Assertion macros for the audio matrix mixer.
`ifndef AUDIO_MATRIX_MIXER_DEFINES_SVH
`define AUDIO_MATRIX_MIXER_DEFINES_SVH

`ifndef SYNTH
// Clocked check, quiet while reset is high.
`define AMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs through reset.
`define AMM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMM_ASSERT(label, clk, rst, prop, msg)
`define AMM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* design/amm_pkg.sv */
package amm_pkg;

   localparam int IN_CHANNELS_DEF  = 2;
   localparam int OUT_CHANNELS_DEF = 6;

   // Fixed port layout: two sample inputs, six sample outputs.
   localparam int FIELD_INS  = 2;
   localparam int FIELD_OUTS = 6;

   localparam int TBL_MAX   = FIELD_INS * FIELD_OUTS;
   localparam int TBL_IDX_W = $clog2(TBL_MAX);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_GAIN = 2'd2;

   typedef logic signed [31:0] sample_type;
   typedef logic signed [63:0] prod_type;

   localparam sample_type TAP_GAIN_RESET       = 32'sh4000_0000;
   localparam sample_type DEFAULT_MASTER_GAIN  = 32'sh4000_0000;
   localparam sample_type Q_MAX = 32'sh7FFF_FFFF;
   localparam sample_type Q_MIN = 32'sh8000_0000;

   localparam logic [2:0] MODE_DEF = 3'd1;
   localparam logic [2:0] MODE_LAST = 3'd4;
   localparam logic [2:0] MODE_COUNT [5] = '{3'd2, 3'd4, 3'd5, 3'd5, 3'd6};

   typedef enum logic {
      KIND_MIX  = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   // One queued word: a sample frame or a gain-table write.
   typedef struct packed {
      kind_type                              kind;
      logic                                  load_ok;
      logic [TBL_IDX_W-1:0]                  load_idx;
      logic [FIELD_INS-1:0][31:0]            data;
   } qword_type;

   typedef struct packed {
      logic       mix_enable;
      logic [2:0] active;
      sample_type master_gain;
   } cfg_type;

   // Modes above the table's end act as the last mode.
   function automatic logic [2:0] mode_count(logic [2:0] mode);
      logic [2:0] m;
      m = (mode > MODE_LAST) ? MODE_LAST : mode;
      return MODE_COUNT[m];
   endfunction

   // Q1.31 product: floor shift by 31, saturate to 32 bits.
   function automatic sample_type q_scale(prod_type p);
      prod_type s;
      s = p >>> 31;
      if (s[63:31] != {33{s[63]}}) begin
         return s[63] ? Q_MIN : Q_MAX;
      end
      return s[31:0];
   endfunction

   function automatic sample_type sat_add(sample_type a, sample_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q_MIN : Q_MAX;
      end
      return s[31:0];
   endfunction

endpackage

/* design/amm_front.sv */
module amm_front #(
   parameter int IN_CHANNELS  = amm_pkg::IN_CHANNELS_DEF,
   parameter int OUT_CHANNELS = amm_pkg::OUT_CHANNELS_DEF
) (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  amm_pkg::sample_type   req_sample_in_0,
   input  amm_pkg::sample_type   req_sample_in_1,
   input  logic                  req_coef_source,
   input  logic [2:0]            req_coef_dest,
   input  amm_pkg::sample_type   req_coef_value,
   output logic                  push_valid,
   input  logic                  push_ready,
   output amm_pkg::qword_type    push_word
);

   localparam logic [1:0] IN_N  = 2'(IN_CHANNELS);
   localparam logic [3:0] OUT_N = 4'(OUT_CHANNELS);

   logic       is_load;
   logic       src_ok;
   logic       dst_ok;
   logic [3:0] flat_idx;

   assign is_load  = req_func;
   assign src_ok   = {1'b0, req_coef_source} < IN_N;
   assign dst_ok   = {1'b0, req_coef_dest} < OUT_N;
   // entry = source * OUT_CHANNELS + dest
   assign flat_idx = ({3'b000, req_coef_source} * OUT_N) + {1'b0, req_coef_dest};

   always_comb begin
      push_word.kind     = is_load ? amm_pkg::KIND_LOAD : amm_pkg::KIND_MIX;
      push_word.load_ok  = is_load && src_ok && dst_ok;
      push_word.load_idx = amm_pkg::TBL_IDX_W'(flat_idx);
      // Loads carry the gain in lane 0.
      push_word.data[0]  = is_load ? req_coef_value : req_sample_in_0;
      push_word.data[1]  = req_sample_in_1;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

/* design/amm_queue.sv */
module amm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  amm_pkg::qword_type push_word,
   output logic               pop_valid,
   input  logic               pop_ready,
   output amm_pkg::qword_type pop_word
);

   amm_pkg::qword_type                 entry_ff [amm_pkg::QUEUE_DEPTH];
   logic [amm_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [amm_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [amm_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                               do_push, do_pop;

   assign push_ready = count_ff != amm_pkg::QCNT_W'(amm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_word   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* design/amm_back.sv */
module amm_back #(
   parameter int IN_CHANNELS  = amm_pkg::IN_CHANNELS_DEF,
   parameter int OUT_CHANNELS = amm_pkg::OUT_CHANNELS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  amm_pkg::cfg_type                             cfg,
   input  logic                                         pop_valid,
   output logic                                         pop_ready,
   input  amm_pkg::qword_type                           pop_word,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output amm_pkg::sample_type [amm_pkg::FIELD_OUTS-1:0] rsp_out,
   output logic [2:0]                                   rsp_active
);

`include "audio_matrix_mixer_defines.svh"

   localparam int         TBL   = IN_CHANNELS * OUT_CHANNELS;
   localparam logic [2:0] OUT_N = 3'(OUT_CHANNELS);

   amm_pkg::sample_type gain_ff [TBL];

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance, pop_mix, pop_load;

   amm_pkg::prod_type   prod_ff  [IN_CHANNELS][OUT_CHANNELS];
   amm_pkg::sample_type samp1_ff [IN_CHANNELS];
   amm_pkg::sample_type samp2_ff [IN_CHANNELS];
   amm_pkg::sample_type samp3_ff [IN_CHANNELS];
   amm_pkg::sample_type acc_ff   [OUT_CHANNELS];
   amm_pkg::sample_type acc_in   [OUT_CHANNELS];
   amm_pkg::prod_type   mprod_ff [OUT_CHANNELS];

   amm_pkg::sample_type rsp_out_ff [amm_pkg::FIELD_OUTS];
   amm_pkg::sample_type rsp_out_in [amm_pkg::FIELD_OUTS];
   logic [2:0]          rsp_active_ff;

   // Whole pipe moves together; bubbles ride along.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (pop_word.kind == amm_pkg::KIND_LOAD) || advance;
   assign pop_mix   = pop_valid && pop_ready && (pop_word.kind == amm_pkg::KIND_MIX);
   assign pop_load  = pop_valid && (pop_word.kind == amm_pkg::KIND_LOAD);

   // Gain table: written in queue order, so later frames see the load.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TBL; k++) begin
            gain_ff[k] <= amm_pkg::TAP_GAIN_RESET;
         end
      end else if (pop_load && pop_word.load_ok) begin
         for (int k = 0; k < TBL; k++) begin
            if (pop_word.load_idx == amm_pkg::TBL_IDX_W'(k)) begin
               gain_ff[k] <= pop_word.data[0];
            end
         end
      end
   end

   always_comb begin
      v1_in        = pop_mix;
      v2_in        = v1_ff;
      v3_in        = v2_ff;
      rsp_valid_in = v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Saturating accumulation over the inputs of each output.
   always_comb begin
      for (int o = 0; o < OUT_CHANNELS; o++) begin
         acc_in[o] = '0;
         for (int i = 0; i < IN_CHANNELS; i++) begin
            acc_in[o] = amm_pkg::sat_add(acc_in[o], amm_pkg::q_scale(prod_ff[i][o]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < IN_CHANNELS; i++) begin
            for (int o = 0; o < OUT_CHANNELS; o++) begin
               prod_ff[i][o] <= amm_pkg::prod_type'(gain_ff[i * OUT_CHANNELS + o])
                              * amm_pkg::prod_type'(amm_pkg::sample_type'(pop_word.data[i]));
            end
            samp1_ff[i] <= pop_word.data[i];
            samp2_ff[i] <= samp1_ff[i];
            samp3_ff[i] <= samp2_ff[i];
         end
         for (int o = 0; o < OUT_CHANNELS; o++) begin
            acc_ff[o]   <= acc_in[o];
            mprod_ff[o] <= amm_pkg::prod_type'(acc_ff[o])
                         * amm_pkg::prod_type'(cfg.master_gain);
         end
         for (int o = 0; o < amm_pkg::FIELD_OUTS; o++) begin
            rsp_out_ff[o] <= rsp_out_in[o];
         end
         rsp_active_ff <= cfg.active;
      end
   end

   for (genvar o = 0; o < amm_pkg::FIELD_OUTS; o++) begin : g_out
      if (o < OUT_CHANNELS) begin : g_used
         amm_pkg::sample_type byp;
         if (o < IN_CHANNELS) begin : g_byp
            assign byp = samp3_ff[o];
         end else begin : g_nobyp
            assign byp = '0;
         end
         always_comb begin
            if (3'(o) >= cfg.active) begin
               rsp_out_in[o] = '0;
            end else if (cfg.mix_enable) begin
               rsp_out_in[o] = amm_pkg::q_scale(mprod_ff[o]);
            end else begin
               rsp_out_in[o] = byp;
            end
         end
      end else begin : g_unused
         assign rsp_out_in[o] = '0;
      end
      assign rsp_out[o] = rsp_out_ff[o];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_active = rsp_active_ff;

   `AMM_ASSERT(a_stall_holds, clock, reset, (!reset && !advance) |=> (rsp_valid_ff && $stable(v1_ff) && $stable(v2_ff) && $stable(v3_ff)), "pipe moved while output stalled")
   `AMM_ASSERT(a_active_range, clock, reset, rsp_valid_ff |-> (rsp_active_ff >= 3'd2 && rsp_active_ff <= OUT_N), "active count out of range")
   `AMM_ASSERT(a_inactive_zero, clock, reset, (rsp_valid_ff && rsp_active_ff < 3'd6) |-> (rsp_out_ff[amm_pkg::FIELD_OUTS-1] == '0), "inactive output not zero")

endmodule

/* design/audio_matrix_mixer.sv */
// Matrix mixer for Q1.31 audio: one request word is either a sample frame
// (req_func = 0) or a gain-table load (req_func = 1). A frame gives one
// response word; each active output is the saturated sum of gain * sample
// over the inputs, scaled by master_gain with saturation, or with
// mix_enable low the inputs copied straight to the first outputs.
// Outputs at or beyond rsp_active_outputs read zero. A load gives no
// response. Throughput is one word per cycle while the output is not
// stalled: a two-entry queue sits between the request decode and the
// multiply pipe, and a frame leaves the queue into four register stages
// (gain multiply, accumulate, master multiply, output register) before
// rsp_valid rises. Loads retire from the queue even while the output is
// stalled, and take effect for every later frame.
// Config registers (csr_index): 0 mix_enable, 1 output_mode, 2 master_gain;
// csr_ready is always high, and writes are meant for an idle block.
module audio_matrix_mixer #(
   parameter int IN_CHANNELS  = amm_pkg::IN_CHANNELS_DEF,
   parameter int OUT_CHANNELS = amm_pkg::OUT_CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // config write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [amm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata,
   // request words
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  amm_pkg::sample_type              req_sample_in_0,
   input  amm_pkg::sample_type              req_sample_in_1,
   input  logic                             req_coef_source,
   input  logic [2:0]                       req_coef_dest,
   input  amm_pkg::sample_type              req_coef_value,
   // response words
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output amm_pkg::sample_type              rsp_out_0,
   output amm_pkg::sample_type              rsp_out_1,
   output amm_pkg::sample_type              rsp_out_2,
   output amm_pkg::sample_type              rsp_out_3,
   output amm_pkg::sample_type              rsp_out_4,
   output amm_pkg::sample_type              rsp_out_5,
   output logic [2:0]                       rsp_active_outputs
);

   localparam logic [2:0] OUT_N = 3'(OUT_CHANNELS);

   // Config registers
   logic                mix_enable_ff, mix_enable_in;
   logic [2:0]          output_mode_ff, output_mode_in;
   amm_pkg::sample_type master_gain_ff, master_gain_in;
   logic                csr_write;
   logic [2:0]          mode_cnt;
   amm_pkg::cfg_type    cfg;

   // Front to queue to back
   logic                push_valid, push_ready;
   amm_pkg::qword_type  push_word;
   logic                pop_valid, pop_ready;
   amm_pkg::qword_type  pop_word;

   amm_pkg::sample_type [amm_pkg::FIELD_OUTS-1:0] rsp_out;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      mix_enable_in  = mix_enable_ff;
      output_mode_in = output_mode_ff;
      master_gain_in = master_gain_ff;
      if (csr_write) begin
         case (csr_index)
            amm_pkg::CSR_MIX_ENABLE:  mix_enable_in  = csr_wdata[0];
            amm_pkg::CSR_OUTPUT_MODE: output_mode_in = csr_wdata[2:0];
            amm_pkg::CSR_MASTER_GAIN: master_gain_in = csr_wdata;
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_enable_ff  <= 1'b1;
         output_mode_ff <= amm_pkg::MODE_DEF;
         master_gain_ff <= amm_pkg::DEFAULT_MASTER_GAIN;
      end else begin
         mix_enable_ff  <= mix_enable_in;
         output_mode_ff <= output_mode_in;
         master_gain_ff <= master_gain_in;
      end
   end

   // Active count from the mode table, capped at the channel count.
   assign mode_cnt = amm_pkg::mode_count(output_mode_ff);

   always_comb begin
      cfg.mix_enable  = mix_enable_ff;
      cfg.active      = (mode_cnt > OUT_N) ? OUT_N : mode_cnt;
      cfg.master_gain = master_gain_ff;
   end

   amm_front #(
      .IN_CHANNELS  (IN_CHANNELS),
      .OUT_CHANNELS (OUT_CHANNELS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_sample_in_0 (req_sample_in_0),
      .req_sample_in_1 (req_sample_in_1),
      .req_coef_source (req_coef_source),
      .req_coef_dest   (req_coef_dest),
      .req_coef_value  (req_coef_value),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_word       (push_word)
   );

   amm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   amm_back #(
      .IN_CHANNELS  (IN_CHANNELS),
      .OUT_CHANNELS (OUT_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out    (rsp_out),
      .rsp_active (rsp_active_outputs)
   );

   assign rsp_out_0 = rsp_out[0];
   assign rsp_out_1 = rsp_out[1];
   assign rsp_out_2 = rsp_out[2];
   assign rsp_out_3 = rsp_out[3];
   assign rsp_out_4 = rsp_out[4];
   assign rsp_out_5 = rsp_out[5];

endmodule
